// ===== sv/twsp_pkg.sv =====
// twsp_pkg: item types, code constants and controller/datapath interface
// structs for the three-way status partition block.
// No dependencies.
package twsp_pkg;

  // command codes
  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_SORT = 2'd3;

  // health classes
  localparam logic [1:0] H_SUSCEPTIBLE = 2'd0;
  localparam logic [1:0] H_INFECTED    = 2'd1;
  localparam logic [1:0] H_INFECTIOUS  = 2'd2;
  localparam logic [1:0] H_IMMUNE      = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NOSLOT = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  slot;
    logic [15:0] member_id;
    logic [1:0]  health;
  } twsp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_id;
    logic [1:0]  read_health;
    logic        any_infectious;
    logic [6:0]  case_count;
    logic [6:0]  active_count;
  } twsp_out_t;

  // read address source during the sort walk
  typedef enum logic [1:0] {
    RD_I  = 2'd0,
    RD_N  = 2'd1,
    RD_PL = 2'd2
  } twsp_rd_src_e;

  typedef struct packed {
    logic         accept;      // input item taken this cycle
    logic         rd_en;       // sort-walk table read
    twsp_rd_src_e rd_src;
    logic         exam;        // classify entry at walk index
    logic         pl_step;     // immune entry at place: shrink boundary, step place down
    logic         wr_i_rdata;  // write read entry into walk slot
    logic         wr_pl_cur;   // write held entry into place slot
    logic         wr_n_cur;    // write held entry into case front, advance both
    logic         load_out;    // capture result
  } twsp_cmd_t;

  typedef struct packed {
    logic scan_done;   // walk index reached boundary
    logic rd_immune;   // read entry is immune
    logic rd_case;     // read entry is infected or infectious
    logic need_swap;   // walk index ahead of case front
    logic pl_gt_i;     // place still above walk index
  } twsp_stat_t;

endpackage

// ===== sv/twsp_datapath.sv =====
// twsp_datapath: member table memories, counters, walk registers and
// result register. Driven by twsp_ctrl through twsp_cmd_t; uses twsp_pkg.
module twsp_datapath import twsp_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  twsp_in_t   in_i,
  input  twsp_cmd_t  ctl_i,
  output twsp_stat_t stat_o,
  output twsp_out_t  out_o
);

  localparam int unsigned IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int unsigned CW = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned SW = (CW > 6) ? CW : 6;
  localparam int unsigned XW = CW + 7;

  logic [15:0] id_mem [MAX_MEMBERS];
  logic [1:0]  hl_mem [MAX_MEMBERS];
  logic [15:0] rd_id_q;
  logic [1:0]  rd_h_q;

  logic [CW-1:0] mc_q, mc_d, ab_q, ab_d, i_q, i_d, n_q, n_d, pl_q, pl_d;
  logic          inf_q, inf_d;
  logic [1:0]    cmd_q, cmd_d, status_q, status_d;
  logic [15:0]   cur_id_q;
  logic [1:0]    cur_h_q;
  twsp_out_t     out_q, out_d;

  logic          full, slot_ok;
  logic [IW+5:0] slot_x;
  logic [IW-1:0] slot_idx;
  logic          id_we, hl_we, rd_en;
  logic [IW-1:0] wa, ra;
  logic [15:0]   wid;
  logic [1:0]    wh;
  logic [XW-1:0] ab_x, n_x;

  assign full     = mc_q >= CW'(MAX_MEMBERS);
  assign slot_ok  = SW'(in_i.slot) < SW'(mc_q);
  assign slot_x   = (IW + 6)'(in_i.slot);
  assign slot_idx = slot_x[IW-1:0];

  // single write port shared by add, set and the sort swaps
  always_comb begin
    id_we = 1'b0;
    hl_we = 1'b0;
    wa    = '0;
    wid   = in_i.member_id;
    wh    = in_i.health;
    if (ctl_i.accept && in_i.command == CMD_ADD && !full) begin
      id_we = 1'b1;
      hl_we = 1'b1;
      wa    = mc_q[IW-1:0];
    end else if (ctl_i.accept && in_i.command == CMD_SET && slot_ok) begin
      hl_we = 1'b1;
      wa    = slot_idx;
    end else if (ctl_i.wr_i_rdata) begin
      id_we = 1'b1;
      hl_we = 1'b1;
      wa    = i_q[IW-1:0];
      wid   = rd_id_q;
      wh    = rd_h_q;
    end else if (ctl_i.wr_pl_cur) begin
      id_we = 1'b1;
      hl_we = 1'b1;
      wa    = pl_q[IW-1:0];
      wid   = cur_id_q;
      wh    = cur_h_q;
    end else if (ctl_i.wr_n_cur) begin
      id_we = 1'b1;
      hl_we = 1'b1;
      wa    = n_q[IW-1:0];
      wid   = cur_id_q;
      wh    = cur_h_q;
    end
  end

  // single read port
  always_comb begin
    rd_en = 1'b0;
    ra    = slot_idx;
    if (ctl_i.accept && in_i.command == CMD_READ) begin
      rd_en = 1'b1;
    end else if (ctl_i.rd_en) begin
      rd_en = 1'b1;
      case (ctl_i.rd_src)
        RD_I:    ra = i_q[IW-1:0];
        RD_N:    ra = n_q[IW-1:0];
        RD_PL:   ra = pl_q[IW-1:0];
        default: ra = i_q[IW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) id_mem[wa] <= wid;
    if (hl_we) hl_mem[wa] <= wh;
    if (rd_en) begin
      rd_id_q <= id_mem[ra];
      rd_h_q  <= hl_mem[ra];
    end
  end

  always_comb begin
    mc_d     = mc_q;
    ab_d     = ab_q;
    i_d      = i_q;
    n_d      = n_q;
    pl_d     = pl_q;
    inf_d    = inf_q;
    cmd_d    = cmd_q;
    status_d = status_q;
    if (ctl_i.accept) begin
      cmd_d    = in_i.command;
      status_d = ST_OK;
      case (in_i.command)
        CMD_ADD: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mc_d = mc_q + CW'(1);
            ab_d = ab_q + CW'(1);
          end
        end
        CMD_SET, CMD_READ: begin
          if (!slot_ok) status_d = ST_NOSLOT;
        end
        CMD_SORT: begin
          ab_d  = (ab_q > mc_q) ? mc_q : ab_q;
          i_d   = '0;
          n_d   = '0;
          inf_d = 1'b0;
        end
        default: ;
      endcase
    end
    if (ctl_i.exam) begin
      if (rd_h_q == H_IMMUNE) begin
        ab_d = ab_q - CW'(1);
        pl_d = ab_q - CW'(1);
      end else if (rd_h_q != H_SUSCEPTIBLE) begin
        if (rd_h_q == H_INFECTIOUS) inf_d = 1'b1;
        if (!(i_q > n_q)) begin
          n_d = n_q + CW'(1);
          i_d = i_q + CW'(1);
        end
      end else begin
        i_d = i_q + CW'(1);
      end
    end
    if (ctl_i.pl_step) begin
      ab_d = ab_q - CW'(1);
      pl_d = pl_q - CW'(1);
    end
    if (ctl_i.wr_n_cur) begin
      n_d = n_q + CW'(1);
      i_d = i_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q     <= '0;
      ab_q     <= '0;
      i_q      <= '0;
      n_q      <= '0;
      pl_q     <= '0;
      inf_q    <= 1'b0;
      cmd_q    <= CMD_ADD;
      status_q <= ST_OK;
    end else begin
      mc_q     <= mc_d;
      ab_q     <= ab_d;
      i_q      <= i_d;
      n_q      <= n_d;
      pl_q     <= pl_d;
      inf_q    <= inf_d;
      cmd_q    <= cmd_d;
      status_q <= status_d;
    end
  end

  // entry held while its partner is fetched for a swap
  always_ff @(posedge clk_i) begin
    if (ctl_i.exam) begin
      cur_id_q <= rd_id_q;
      cur_h_q  <= rd_h_q;
    end
    if (ctl_i.load_out) out_q <= out_d;
  end

  assign ab_x = XW'(ab_q);
  assign n_x  = XW'(n_q);

  always_comb begin
    out_d                = '0;
    out_d.status         = status_q;
    out_d.active_count   = ab_x[6:0];
    if (cmd_q == CMD_READ && status_q == ST_OK) begin
      out_d.read_id     = rd_id_q;
      out_d.read_health = rd_h_q;
    end
    if (cmd_q == CMD_SORT) begin
      out_d.any_infectious = inf_q;
      out_d.case_count     = n_x[6:0];
    end
  end

  assign out_o            = out_q;
  assign stat_o.scan_done = i_q >= ab_q;
  assign stat_o.rd_immune = rd_h_q == H_IMMUNE;
  assign stat_o.rd_case   = rd_h_q != H_SUSCEPTIBLE && rd_h_q != H_IMMUNE;
  assign stat_o.need_swap = i_q > n_q;
  assign stat_o.pl_gt_i   = pl_q > i_q;

endmodule

// ===== sv/twsp_ctrl.sv =====
// twsp_ctrl: command sequencer for the partition block. Handles the
// input/output handshakes and steps the sort walk; uses twsp_pkg.
module twsp_ctrl import twsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_command_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  twsp_stat_t stat_i,
  output twsp_cmd_t  ctl_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_RESP    = 9'b000000010,
    S_SCAN    = 9'b000000100,
    S_EXAM    = 9'b000001000,
    S_CSWAP_A = 9'b000010000,
    S_CSWAP_B = 9'b000100000,
    S_PCHK    = 9'b001000000,
    S_PEXAM   = 9'b010000000,
    S_PSWAP_B = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.accept = 1'b1;
          state_d = (in_command_i == CMD_SORT) ? S_SCAN : S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ctl_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_RESP;
        end else begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_src = RD_I;
          state_d = S_EXAM;
        end
      end
      S_EXAM: begin
        ctl_o.exam = 1'b1;
        if (stat_i.rd_immune) begin
          state_d = S_PCHK;
        end else if (stat_i.rd_case && stat_i.need_swap) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_src = RD_N;
          state_d = S_CSWAP_A;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_CSWAP_A: begin
        ctl_o.wr_i_rdata = 1'b1;
        state_d = S_CSWAP_B;
      end
      S_CSWAP_B: begin
        ctl_o.wr_n_cur = 1'b1;
        state_d = S_SCAN;
      end
      S_PCHK: begin
        if (stat_i.pl_gt_i) begin
          ctl_o.rd_en  = 1'b1;
          ctl_o.rd_src = RD_PL;
          state_d = S_PEXAM;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_PEXAM: begin
        if (stat_i.rd_immune) begin
          ctl_o.pl_step = 1'b1;
          state_d = S_PCHK;
        end else begin
          ctl_o.wr_i_rdata = 1'b1;
          state_d = S_PSWAP_B;
        end
      end
      S_PSWAP_B: begin
        // swapped-in entry goes back through the scan and is examined again
        ctl_o.wr_pl_cur = 1'b1;
        state_d = S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = ctl_o.load_out ? 1'b1 : (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/three_way_status_partition.sv =====
// Member table of up to MAX_MEMBERS entries (16-bit id, 2-bit health) with
// an active boundary. One item in, one result out. Add, set and read go
// through accept, then respond; the result register loads in the respond
// step, with read data from the registered table port. Sort walks the
// active region on a single-read, single-write table: each entry is read,
// then examined (an entry swapped into the walk slot is examined again); a
// case that moves to the front is swapped with the case front, an immune
// entry at the walk index starts a check from the back, immune entries at
// the back are skipped and an immune entry is swapped with the last
// non-immune one; then the result loads. A stalled output delays that load.
// Input is taken only when the sequencer is idle; the result register holds
// a finished result while the next item is accepted.
module three_way_status_partition import twsp_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  twsp_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output twsp_out_t out_o
);

  twsp_cmd_t  ctl;
  twsp_stat_t stat;

  twsp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_i.command),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stat_i       (stat),
    .ctl_o        (ctl)
  );

  twsp_datapath #(
    .MAX_MEMBERS (MAX_MEMBERS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctl_i  (ctl),
    .stat_o (stat),
    .out_o  (out_o)
  );

  // result register is never overwritten while a result waits
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a pending result");

  // one table write source per cycle in the walk
  a_wr_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.wr_i_rdata, ctl.wr_pl_cur, ctl.wr_n_cur, ctl.accept}))
    else $error("conflicting table writes");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.status == ST_OK || out_o.status == ST_FULL ||
                     out_o.status == ST_NOSLOT))
    else $error("bad status code");

  // sort fields only on sort results, read fields only on good reads
  a_field_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_o.read_id != 16'd0 || out_o.read_health != 2'd0))
    |-> (out_o.status == ST_OK && out_o.case_count == 7'd0 &&
         !out_o.any_infectious))
    else $error("read and sort fields mixed");

endmodule

// ===== tb/twsp_checker.sv =====
// twsp_checker: watches both channels of three_way_status_partition, keeps
// its own copy of the member table and compares every result item in order.
// Depends on twsp_pkg.
module twsp_checker import twsp_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_o,
  input  twsp_in_t  in_i,
  input  logic      out_valid_o,
  input  logic      out_stall_i,
  input  twsp_out_t out_o,
  output int        mismatches_o,
  output int        owed_o
);

  localparam int unsigned IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  logic [15:0] id_copy     [MAX_MEMBERS];
  logic [1:0]  health_copy [MAX_MEMBERS];
  int          members;
  int          boundary;
  twsp_out_t   owed_responses [$];
  twsp_out_t   want;
  int          faults = 0;

  assign mismatches_o = faults;

  function automatic void exchange(int a, int b);
    logic [15:0] tid;
    logic [1:0]  th;
    tid = id_copy[IW'(a)];
    th = health_copy[IW'(a)];
    id_copy[IW'(a)] = id_copy[IW'(b)];
    health_copy[IW'(a)] = health_copy[IW'(b)];
    id_copy[IW'(b)] = tid;
    health_copy[IW'(b)] = th;
  endfunction

  // Applies one item to the table copy and returns the result it owes.
  function automatic twsp_out_t table_response(twsp_in_t it);
    twsp_out_t r;
    int        i;
    int        n;
    int        place;
    logic      inf;
    logic      swapped;
    r = '0;
    i = 0;
    n = 0;
    inf = 1'b0;
    case (it.command)
      CMD_ADD: begin
        if (members >= MAX_MEMBERS) begin
          r.status = ST_FULL;
        end else begin
          id_copy[IW'(members)] = it.member_id;
          health_copy[IW'(members)] = it.health;
          members++;
          boundary++;
        end
      end
      CMD_SET: begin
        if (it.slot < members) health_copy[IW'(it.slot)] = it.health;
        else r.status = ST_NOSLOT;
      end
      CMD_READ: begin
        if (it.slot < members) begin
          r.read_id = id_copy[IW'(it.slot)];
          r.read_health = health_copy[IW'(it.slot)];
        end else begin
          r.status = ST_NOSLOT;
        end
      end
      default: begin
        if (boundary > members) boundary = members;
        while (i < boundary) begin
          if (health_copy[IW'(i)] == H_IMMUNE) begin
            // pull the last non-immune entry forward; immune ones at the
            // back just shrink the boundary. Slot i is looked at again.
            place = boundary - 1;
            swapped = 1'b0;
            boundary--;
            while (!swapped && place > i) begin
              if (health_copy[IW'(place)] == H_IMMUNE) begin
                boundary--;
                place--;
              end else begin
                exchange(i, place);
                swapped = 1'b1;
              end
            end
          end else if (health_copy[IW'(i)] != H_SUSCEPTIBLE) begin
            if (health_copy[IW'(i)] == H_INFECTIOUS) inf = 1'b1;
            if (i > n) exchange(i, n);
            n++;
            i++;
          end else begin
            i++;
          end
        end
        r.any_infectious = inf;
        r.case_count = n[6:0];
      end
    endcase
    r.active_count = boundary[6:0];
    return r;
  endfunction

  task automatic note_fault(string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val)
      note_fault($sformatf("%s expected %0h got %0h", name, exp_val, got_val));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      members = 0;
      boundary = 0;
      owed_responses.delete();
      owed_o = 0;
    end else begin
      // a result never belongs to the item taken at the same edge
      if (out_valid_o && !out_stall_i) begin
        if (owed_responses.size() == 0) begin
          note_fault($sformatf("result %h with none outstanding", out_o));
        end else begin
          want = owed_responses.pop_front();
          check_field("status", want.status, out_o.status);
          check_field("read_id", want.read_id, out_o.read_id);
          check_field("read_health", want.read_health, out_o.read_health);
          check_field("any_infectious", want.any_infectious, out_o.any_infectious);
          check_field("case_count", want.case_count, out_o.case_count);
          check_field("active_count", want.active_count, out_o.active_count);
        end
      end
      if (in_valid_i && !in_stall_o) owed_responses.push_back(table_response(in_i));
      owed_o = owed_responses.size();
    end
  end

endmodule

// ===== tb/tb_three_way_status_partition.sv =====
// tb_three_way_status_partition: drives directed and random commands into the
// member table with random gaps and stalls, and gives the verdict.
// Depends on twsp_pkg, three_way_status_partition and twsp_checker.
module tb_three_way_status_partition;
  import twsp_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 600000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  twsp_in_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  twsp_out_t out_o;
  int        mismatches;
  int        owed;
  int        tx_idle_pct = 30;
  int        rx_idle_pct = 54;
  int        table_fill = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  three_way_status_partition #(.MAX_MEMBERS(TABLE_DEPTH)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  twsp_checker #(.MAX_MEMBERS(TABLE_DEPTH)) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .mismatches_o(mismatches),
    .owed_o      (owed)
  );

  // Receiver: random stalls, plus two long hold-offs so the block backs up.
  int items_taken = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      items_taken++;
      if (items_taken == 60 || items_taken == 300) hold_left = HOLD_CYCLES;
    end
    out_stall_i <= (hold_left > 0) || ($urandom_range(0, 99) < rx_idle_pct);
    if (hold_left > 0) hold_left--;
  end

  function automatic twsp_in_t make_item(logic [1:0] cmd, logic [5:0] slot,
                                         logic [15:0] id, logic [1:0] h);
    twsp_in_t it;
    it.command = cmd;
    it.slot = slot;
    it.member_id = id;
    it.health = h;
    return it;
  endfunction

  function automatic twsp_in_t random_item();
    twsp_in_t it;
    int       pick;
    pick = $urandom_range(0, 99);
    it.slot = 6'($urandom_range(0, 63));
    it.member_id = 16'($urandom_range(0, 65535));
    it.health = 2'($urandom_range(0, 3));
    if (pick < 22) it.command = CMD_ADD;
    else if (pick < 55) it.command = CMD_SET;
    else if (pick < 75) it.command = CMD_READ;
    else it.command = CMD_SORT;
    // mostly aim set and read at occupied slots
    if (table_fill > 0 && $urandom_range(0, 99) < 85)
      it.slot = 6'($urandom_range(0, table_fill - 1));
    return it;
  endfunction

  // Leaves valid high after acceptance; the next call lowers it only for a gap.
  task automatic offer(input twsp_in_t item);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.command == CMD_ADD && table_fill < TABLE_DEPTH) table_fill++;
  endtask

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int k;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: unoccupied slots and a sort with nothing active
    offer(make_item(CMD_READ, 6'd0, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_SET, 6'd63, 16'hFFFF, H_IMMUNE));
    offer(make_item(CMD_SORT, 6'd0, 16'h0000, H_SUSCEPTIBLE));
    // immune entries at the back and in the middle, so a swapped-in case
    // gets examined again
    offer(make_item(CMD_ADD, 6'd63, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_ADD, 6'd0, 16'hFFFF, H_IMMUNE));
    offer(make_item(CMD_ADD, 6'd0, 16'h1234, H_INFECTIOUS));
    offer(make_item(CMD_ADD, 6'd0, 16'hA5A5, H_IMMUNE));
    offer(make_item(CMD_ADD, 6'd0, 16'h5A5A, H_INFECTED));
    offer(make_item(CMD_ADD, 6'd0, 16'h8001, H_IMMUNE));
    offer(make_item(CMD_SORT, 6'd0, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_READ, 6'd0, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_READ, 6'd2, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_READ, 6'd5, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_SET, 6'd0, 16'h0000, H_IMMUNE));
    offer(make_item(CMD_SET, 6'd1, 16'h0000, H_INFECTIOUS));
    offer(make_item(CMD_SORT, 6'd0, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_READ, 6'd6, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_READ, 6'd63, 16'hFFFF, H_IMMUNE));
    offer(make_item(CMD_ADD, 6'd0, 16'h7FFF, H_INFECTED));
    offer(make_item(CMD_SORT, 6'd0, 16'h0000, H_SUSCEPTIBLE));
    offer(make_item(CMD_READ, 6'd1, 16'h0000, H_SUSCEPTIBLE));

    // random part; the table fills up about two thirds of the way through
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 54;
        rx_idle_pct = 30;
      end
      if (k == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      offer(random_item());
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && owed == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/twsp_pkg.sv
sv/twsp_datapath.sv
sv/twsp_ctrl.sv
sv/three_way_status_partition.sv
tb/twsp_checker.sv
tb/tb_three_way_status_partition.sv
